[rtl/core/mctw_pkg.sv]
// Shared types and codes for the two-stage watchdog bank.
package mctw_pkg;

    // Command codes
    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_CREATE  = 3'd1;
    localparam logic [2:0] CMD_START   = 3'd2;
    localparam logic [2:0] CMD_STOP    = 3'd3;
    localparam logic [2:0] CMD_REFRESH = 3'd4;
    localparam logic [2:0] CMD_DELETE  = 3'd5;

    // Result kinds
    localparam logic [2:0] KIND_STATUS   = 3'd0;
    localparam logic [2:0] KIND_SIGNALED = 3'd1;
    localparam logic [2:0] KIND_ACTION   = 3'd2;
    localparam logic [2:0] KIND_SIG_ACT  = 3'd3;
    localparam logic [2:0] KIND_IDLE     = 3'd4;

    // Status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_INVALID = 2'd1;
    localparam logic [1:0] STAT_STARTED = 2'd2;

    // Run states and action codes
    localparam logic [1:0] RUN_STOPPED  = 2'd0;
    localparam logic [1:0] RUN_STARTED  = 2'd1;
    localparam logic [1:0] RUN_SIGNALED = 2'd2;
    localparam logic [1:0] ACT_REJECT   = 2'd3;

    localparam int MAX_OUT = 8;

    // Classified request handed from the front to the back
    typedef struct packed {
        logic        is_tick;   // a tick that passed the flag check
        logic        rejected;  // answer with status only, change nothing
        logic [2:0]  cmd;
        logic [5:0]  channel;
        logic [30:0] period_ticks;
        logic [30:0] wait_ticks;
        logic [1:0]  default_action;
        logic [31:0] action_argument;
        logic [7:0]  owner_id;
    } req_t;

endpackage

[rtl/core/mctw_front.sv]
// Front end: accepts requests, checks flags and range, and queues them.
module mctw_front #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [2:0]            cmd,
    input  logic [2:0]            channel,
    input  logic [30:0]           period_ticks,
    input  logic [30:0]           wait_ticks,
    input  logic [1:0]            default_action,
    input  logic [31:0]           action_argument,
    input  logic [7:0]            owner_id,
    input  logic [7:0]            request_flags,
    output logic                  q_valid,
    input  logic                  q_ready,
    output mctw_pkg::req_t        q_req
);
    import mctw_pkg::*;

    req_t       slot_reg [2];
    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, rd_ptr_reg;
    req_t       cls;
    logic       push, pop;

    // Classify the incoming request
    always_comb
    begin
        cls                 = '0;
        cls.cmd             = cmd;
        cls.channel         = {3'd0, channel};
        cls.period_ticks    = period_ticks;
        cls.wait_ticks      = wait_ticks;
        cls.default_action  = default_action;
        cls.action_argument = action_argument;
        cls.owner_id        = owner_id;
        if (request_flags != 8'd0)
        begin
            cls.rejected = 1'b1;
            if (cmd == CMD_TICK)
                cls.channel = '0;
        end
        else if (cmd == CMD_TICK)
            cls.is_tick = 1'b1;
        else if (cmd > CMD_DELETE || 32'(channel) >= 32'(NUM_CHANNELS))
            cls.rejected = 1'b1;
        else if (cmd == CMD_CREATE && (period_ticks == '0 || default_action == ACT_REJECT))
            cls.rejected = 1'b1;
    end

    // Two-entry queue toward the back end
    assign in_ready   = (count_reg != 2'd2);
    assign q_valid    = (count_reg != 2'd0);
    assign q_req      = slot_reg[rd_ptr_reg];
    assign push       = in_valid && in_ready;
    assign pop        = q_valid && q_ready;
    assign count_next = count_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= cls;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end
endmodule

[rtl/core/mctw_back.sv]
// Back end: channel state, command execution and the tick scan.
module mctw_back #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    output logic           q_ready,
    input  mctw_pkg::req_t q_req,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [2:0]     kind,
    output logic [1:0]     status,
    output logic [2:0]     out_channel,
    output logic [1:0]     action_taken,
    output logic [31:0]    action_value,
    output logic [7:0]     victim_owner,
    output logic           last
);
    import mctw_pkg::*;

    localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int NW = $clog2(NUM_CHANNELS + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [31:0] now_reg;
    logic [NUM_CHANNELS-1:0] alloc_reg;
    logic [1:0]  run_reg    [NUM_CHANNELS];
    logic [31:0] expiry_reg [NUM_CHANNELS];
    logic [30:0] period_reg [NUM_CHANNELS];
    logic [30:0] wait_reg   [NUM_CHANNELS];
    logic [1:0]  action_reg [NUM_CHANNELS];
    logic [31:0] arg_reg    [NUM_CHANNELS];
    logic [7:0]  owner_reg  [NUM_CHANNELS];

    logic [NW-1:0] scan_reg;     // channel index under scan
    logic [3:0]    emitted_reg;  // expiry results in this tick
    logic [CW-1:0] sc;
    logic [31:0]   diff;
    logic          hit;
    logic          scan_done;
    logic          more;
    logic          emit;

    // Output register
    logic          ov_reg;
    logic [2:0]    kind_reg;
    logic [1:0]    status_reg;
    logic [2:0]    ch_reg;
    logic [1:0]    act_reg;
    logic [31:0]   val_reg;
    logic [7:0]    own_reg;
    logic          last_reg;
    logic          out_free;

    assign out_free     = !ov_reg || out_ready;
    assign out_valid    = ov_reg;
    assign kind         = kind_reg;
    assign status       = status_reg;
    assign out_channel  = ch_reg;
    assign action_taken = act_reg;
    assign action_value = val_reg;
    assign victim_owner = own_reg;
    assign last         = last_reg;

    assign q_ready = (state_reg == ST_IDLE) && out_free;
    assign sc      = scan_reg[CW-1:0];
    assign diff    = expiry_reg[sc] - now_reg;
    assign hit     = alloc_reg[sc] && run_reg[sc] != RUN_STOPPED
                     && (diff == 32'd0 || diff[31]);
    assign scan_done = (32'(scan_reg) >= 32'(NUM_CHANNELS - 1));

    // A result is loaded into the output register this cycle.
    assign emit = (state_reg == ST_IDLE && q_valid && q_ready && !q_req.is_tick)
                  || (state_reg == ST_SCAN && out_free
                      && (hit || (scan_done && emitted_reg == 4'd0)));

    // Is another expiry waiting after the current one (lookahead for "last")
    always_comb
    begin
        more = 1'b0;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            if (32'(i) > 32'(scan_reg) && alloc_reg[i] && run_reg[i] != RUN_STOPPED
                && ((expiry_reg[i] - now_reg) == 32'd0 || expiry_reg[i][31:0] - now_reg >= 32'h8000_0000))
                more = 1'b1;
        end
        if (emitted_reg == 4'(MAX_OUT - 1))
            more = 1'b0;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (q_valid && q_ready && q_req.is_tick) state_next = ST_SCAN;
            ST_SCAN: if (out_free && (hit || scan_done)) state_next = (hit && more) ? ST_SCAN
                                                                                     : ST_IDLE;
            ST_EMIT: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Channel state, commands and scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            now_reg     <= '0;
            alloc_reg   <= '0;
            scan_reg    <= '0;
            emitted_reg <= '0;
            ov_reg      <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++)
                run_reg[i] <= RUN_STOPPED;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
            if (state_reg == ST_IDLE && q_valid && q_ready)
            begin
                if (q_req.is_tick)
                begin
                    now_reg     <= now_reg + 32'd1;
                    scan_reg    <= '0;
                    emitted_reg <= '0;
                end
                else
                begin
                    if (!q_req.rejected && q_req.cmd != CMD_CREATE
                        && !alloc_reg[q_req.channel[CW-1:0]])
                        status_reg <= STAT_INVALID;
                    else if (q_req.rejected)
                        status_reg <= STAT_INVALID;
                    else if (q_req.cmd == CMD_START
                             && run_reg[q_req.channel[CW-1:0]] != RUN_STOPPED)
                        status_reg <= STAT_STARTED;
                    else
                        status_reg <= STAT_OK;
                    if (!q_req.rejected)
                    begin
                        case (q_req.cmd)
                            CMD_CREATE:
                                if (!alloc_reg[q_req.channel[CW-1:0]])
                                begin
                                    alloc_reg[q_req.channel[CW-1:0]]  <= 1'b1;
                                    run_reg[q_req.channel[CW-1:0]]    <= RUN_STOPPED;
                                    period_reg[q_req.channel[CW-1:0]] <= q_req.period_ticks;
                                    wait_reg[q_req.channel[CW-1:0]]   <= q_req.wait_ticks;
                                    action_reg[q_req.channel[CW-1:0]] <= q_req.default_action;
                                    arg_reg[q_req.channel[CW-1:0]]    <= q_req.action_argument;
                                end
                            CMD_START:
                                if (alloc_reg[q_req.channel[CW-1:0]]
                                    && run_reg[q_req.channel[CW-1:0]] == RUN_STOPPED)
                                begin
                                    expiry_reg[q_req.channel[CW-1:0]] <= now_reg
                                        + {1'b0, period_reg[q_req.channel[CW-1:0]]};
                                    run_reg[q_req.channel[CW-1:0]]   <= RUN_STARTED;
                                    owner_reg[q_req.channel[CW-1:0]] <= q_req.owner_id;
                                end
                            CMD_STOP:
                                if (alloc_reg[q_req.channel[CW-1:0]])
                                    run_reg[q_req.channel[CW-1:0]] <= RUN_STOPPED;
                            CMD_REFRESH:
                                if (alloc_reg[q_req.channel[CW-1:0]]
                                    && run_reg[q_req.channel[CW-1:0]] != RUN_STOPPED)
                                begin
                                    expiry_reg[q_req.channel[CW-1:0]] <= now_reg
                                        + {1'b0, period_reg[q_req.channel[CW-1:0]]};
                                    run_reg[q_req.channel[CW-1:0]] <= RUN_STARTED;
                                end
                            CMD_DELETE:
                                if (alloc_reg[q_req.channel[CW-1:0]])
                                begin
                                    alloc_reg[q_req.channel[CW-1:0]] <= 1'b0;
                                    run_reg[q_req.channel[CW-1:0]]   <= RUN_STOPPED;
                                end
                            default: ;
                        endcase
                    end
                    kind_reg <= KIND_STATUS;
                    ch_reg   <= q_req.channel[2:0];
                    act_reg  <= '0;
                    val_reg  <= '0;
                    own_reg  <= '0;
                    last_reg <= 1'b1;
                end
            end
            else if (state_reg == ST_SCAN && out_free)
            begin
                if (hit)
                begin
                    status_reg <= STAT_OK;
                    ch_reg   <= 3'(scan_reg);
                    val_reg  <= arg_reg[sc];
                    own_reg  <= owner_reg[sc];
                    last_reg <= !more;
                    emitted_reg <= emitted_reg + 4'd1;
                    if (run_reg[sc] == RUN_STARTED && wait_reg[sc] != '0)
                    begin
                        run_reg[sc]    <= RUN_SIGNALED;
                        expiry_reg[sc] <= now_reg + {1'b0, wait_reg[sc]};
                        kind_reg       <= KIND_SIGNALED;
                        act_reg        <= '0;
                    end
                    else
                    begin
                        kind_reg    <= (run_reg[sc] == RUN_STARTED) ? KIND_SIG_ACT : KIND_ACTION;
                        run_reg[sc] <= RUN_STOPPED;
                        act_reg     <= action_reg[sc];
                    end
                end
                else if (scan_done && emitted_reg == 4'd0)
                begin
                    kind_reg   <= KIND_IDLE;
                    status_reg <= STAT_OK;
                    ch_reg     <= '0;
                    act_reg    <= '0;
                    val_reg    <= '0;
                    own_reg    <= '0;
                    last_reg   <= 1'b1;
                end
                scan_reg <= scan_reg + NW'(1);
            end
        end
    end
endmodule

[rtl/core/multi_channel_two_stage_watchdog.sv]
// Top level of the multi-channel two-stage watchdog bank.
//
//  channel | handshake          | payload
//  --------+--------------------+----------------------------------------------
//  request | in_valid/in_ready  | cmd, channel, period/wait, action, owner, flags
//  result  | out_valid/out_ready| kind, status, out_channel, action, value, last
//
// A command passes through the front queue and is then executed in the back end.
// A tick scans one channel per cycle while no result waits on out_ready, and
// stops after the last expiring channel or after MAX_OUT expiry results.
// Reset clears all channels to free and stopped.
// The two-entry queue lets requests enter while the back end is busy.
module multi_channel_two_stage_watchdog #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  cmd,
    input  logic [2:0]  channel,
    input  logic [30:0] period_ticks,
    input  logic [30:0] wait_ticks,
    input  logic [1:0]  default_action,
    input  logic [31:0] action_argument,
    input  logic [7:0]  owner_id,
    input  logic [7:0]  request_flags,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [1:0]  status,
    output logic [2:0]  out_channel,
    output logic [1:0]  action_taken,
    output logic [31:0] action_value,
    output logic [7:0]  victim_owner,
    output logic        last
);
    import mctw_pkg::*;

    logic q_valid, q_ready;
    req_t q_req;

    mctw_front #(.NUM_CHANNELS(NUM_CHANNELS)) u_front (
        .clk, .rst_n, .in_valid, .in_ready, .cmd, .channel, .period_ticks,
        .wait_ticks, .default_action, .action_argument, .owner_id, .request_flags,
        .q_valid, .q_ready, .q_req
    );

    mctw_back #(.NUM_CHANNELS(NUM_CHANNELS)) u_back (
        .clk, .rst_n, .q_valid, .q_ready, .q_req, .out_valid, .out_ready,
        .kind, .status, .out_channel, .action_taken, .action_value,
        .victim_owner, .last
    );
endmodule
